>>> design/ulps_pkg.sv
// Shared types and constants for the unsorted-list priority store.
// No dependencies; used by ulps_cmp and unsorted_list_priority_store_top.
package ulps_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_ADD        = 2'd0;
  localparam logic [OP_W-1:0] OP_MIN        = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_MAX = 2'd2;
  localparam logic [OP_W-1:0] OP_POP        = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // control for the shared compare unit
  typedef struct packed {
    logic en;        // a read beat is present this cycle
    logic load;      // first entry of the scan: take it unconditionally
    logic find_max;  // 1: keep strict maximum, 0: keep strict minimum
  } cmp_ctrl_t;

endpackage

>>> design/ulps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ulps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ulps_cmp.sv
// Shared compare unit: keeps the running best value and its address over a scan.
// Depends on ulps_pkg.
module ulps_cmp #(
  parameter int unsigned AW = 6
) (
  input  logic                                 clk_i,
  input  ulps_pkg::cmp_ctrl_t                  ctrl_i,
  input  logic signed [ulps_pkg::VALUE_W-1:0]  data_i,
  input  logic [AW-1:0]                        addr_i,
  output logic signed [ulps_pkg::VALUE_W-1:0]  best_o,
  output logic [AW-1:0]                        pos_o
);

  logic signed [ulps_pkg::VALUE_W-1:0] best_q;
  logic [AW-1:0]                       pos_q;
  logic                                better;

  // strict compare: on ties the entry seen first (newest) stays
  assign better = ctrl_i.find_max ? (data_i > best_q) : (data_i < best_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en && (ctrl_i.load || better)) begin
      best_q <= data_i;
      pos_q  <= addr_i;
    end
  end

  assign best_o = best_q;
  assign pos_o  = pos_q;

endmodule

>>> design/unsorted_list_priority_store_top.sv
// Top level of the unsorted-list priority store: sequencer, entry RAM and compare unit.
// Depends on ulps_pkg, ulps_ram and ulps_cmp.
//
// Stores up to CAPACITY signed 32-bit values in insertion order in one RAM and
// works on one beat at a time. s_axis_tready is high only while the sequencer
// is idle. A finished result waits in the output register without holding up
// the next beat's work. With n entries stored, a beat takes these steps until
// its result is loaded into the output register:
//   - add, and any beat that meets an empty or full store: straight to finish.
//   - pop: a read of the newest entry, pop-wait, finish.
//   - query-minimum: a scan of all n entries, newest first, scan-end, finish.
//   - remove-maximum: the same scan and scan-end, plus a move when k > 0
//     entries newer than the removed one move down a place, then finish.
// The result shows up on the master side in the cycle after that. Finish
// holds while an earlier result still waits in the output register.
// The scan and the move both stream through the single RAM read port, one
// entry a cycle, with the compare unit taking one read beat per cycle. No
// clearing pass is needed after reset.
module unsorted_list_priority_store_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // result_value[31:0], count[38:32], is_empty[39]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned VW = ulps_pkg::VALUE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_SHIFT,
    ST_POP_WAIT,
    ST_FINISH
  } state_e;

  state_e                            state_q, state_d;
  logic [CW-1:0]                     cnt_q, cnt_d;
  logic [AW-1:0]                     addr_q, addr_d;
  logic                              iss_q, iss_d;
  logic                              rv_q, rv_d;
  logic [AW-1:0]                     ra_q, ra_d;
  logic [ulps_pkg::OP_W-1:0]         op_q, op_d;
  logic [VW-1:0]                     res_q, res_d;
  logic [ulps_pkg::STATUS_W-1:0]     st_q, st_d;
  logic                              m_valid_q, m_valid_d;
  logic [VW-1:0]                     m_val_q, m_val_d;
  logic [ulps_pkg::STATUS_W-1:0]     m_st_q, m_st_d;
  logic [ulps_pkg::COUNT_W-1:0]      m_cnt_q, m_cnt_d;
  logic                              m_emp_q, m_emp_d;

  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [VW-1:0]                     ram_wdata;
  logic                              ram_re;
  logic [AW-1:0]                     ram_raddr;
  logic [VW-1:0]                     ram_rdata;

  ulps_pkg::cmp_ctrl_t               cmp_ctrl;
  logic signed [VW-1:0]              cmp_best;
  logic [AW-1:0]                     cmp_pos;

  logic [AW-1:0]                     last;
  logic                              full;
  logic                              accept;

  assign last   = AW'(cnt_q - CW'(1));
  assign full   = (cnt_q == CW'(CAPACITY));
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign cmp_ctrl.en       = rv_q && (state_q == ST_SCAN);
  assign cmp_ctrl.load     = (ra_q == last);
  assign cmp_ctrl.find_max = (op_q == ulps_pkg::OP_REMOVE_MAX);

  ulps_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ulps_cmp #(
    .AW (AW)
  ) u_cmp (
    .clk_i  (clk_i),
    .ctrl_i (cmp_ctrl),
    .data_i (ram_rdata),
    .addr_i (ra_q),
    .best_o (cmp_best),
    .pos_o  (cmp_pos)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    iss_d     = iss_q;
    rv_d      = iss_q;
    ra_d      = addr_q;
    op_d      = op_q;
    res_d     = res_q;
    st_d      = st_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_val_d   = m_val_q;
    m_st_d    = m_st_q;
    m_cnt_d   = m_cnt_q;
    m_emp_d   = m_emp_q;
    ram_we    = 1'b0;
    ram_waddr = AW'(cnt_q);
    ram_wdata = s_axis_tdata;
    ram_re    = 1'b0;
    ram_raddr = addr_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = s_axis_tuser;
          res_d = '0;
          st_d  = ulps_pkg::ST_OK;
          if (s_axis_tuser == ulps_pkg::OP_ADD) begin
            if (full) begin
              st_d = ulps_pkg::ST_FULL;
            end else begin
              ram_we = 1'b1;
              cnt_d  = cnt_q + CW'(1);
            end
            state_d = ST_FINISH;
          end else if (cnt_q == '0) begin
            st_d    = ulps_pkg::ST_EMPTY;
            state_d = ST_FINISH;
          end else if (s_axis_tuser == ulps_pkg::OP_POP) begin
            ram_re    = 1'b1;
            ram_raddr = last;
            state_d   = ST_POP_WAIT;
          end else begin
            addr_d  = last;
            iss_d   = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end

      // newest to oldest; read data arrives in the cycle after the address
      ST_SCAN: begin
        if (iss_q) begin
          ram_re = 1'b1;
          if (addr_q == '0) begin
            iss_d = 1'b0;
          end else begin
            addr_d = addr_q - AW'(1);
          end
        end
        if (rv_q && ra_q == '0) begin
          state_d = ST_SCAN_END;
        end
      end

      ST_SCAN_END: begin
        res_d = cmp_best;
        if (op_q == ulps_pkg::OP_REMOVE_MAX) begin
          if (cmp_pos == last) begin
            cnt_d   = cnt_q - CW'(1);
            state_d = ST_FINISH;
          end else begin
            addr_d  = cmp_pos + AW'(1);
            iss_d   = 1'b1;
            state_d = ST_SHIFT;
          end
        end else begin
          state_d = ST_FINISH;
        end
      end

      // close the gap: entry at ra writes back to ra-1
      ST_SHIFT: begin
        if (iss_q) begin
          ram_re = 1'b1;
          if (addr_q == last) begin
            iss_d = 1'b0;
          end else begin
            addr_d = addr_q + AW'(1);
          end
        end
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = ra_q - AW'(1);
          ram_wdata = ram_rdata;
          if (ra_q == last) begin
            cnt_d   = cnt_q - CW'(1);
            state_d = ST_FINISH;
          end
        end
      end

      ST_POP_WAIT: begin
        res_d   = ram_rdata;
        cnt_d   = cnt_q - CW'(1);
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_val_d   = res_q;
          m_st_d    = st_q;
          m_cnt_d   = ulps_pkg::COUNT_W'(cnt_q);
          m_emp_d   = (cnt_q == '0);
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      iss_q     <= 1'b0;
      rv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      iss_q     <= iss_d;
      rv_q      <= rv_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    ra_q    <= ra_d;
    op_q    <= op_d;
    res_q   <= res_d;
    st_q    <= st_d;
    m_val_q <= m_val_d;
    m_st_q  <= m_st_d;
    m_cnt_q <= m_cnt_d;
    m_emp_q <= m_emp_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_emp_q, m_cnt_q, m_val_q};
  assign m_axis_tuser  = m_st_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) <= cnt_q))
    else $error("RAM write beyond stored entries");

  a_read_beat_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == ST_SCAN || state_q == ST_SHIFT))
    else $error("read beat outside scan or shift");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && m_valid_q && !m_axis_tready) |=> (state_q == ST_FINISH))
    else $error("result overwrote a waiting output beat");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == ulps_pkg::OP_ADD && !full) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("add did not raise the count");

endmodule
